[hdl/lnfw_pkg.sv]
// shared types and constants for the lcd number field writer
`default_nettype none

package lnfw_pkg;

    localparam int MAX_DIGITS  = 16;
    localparam int DIG_IDX_W   = 4;
    localparam int CNT_W       = 5;
    localparam int MAG_W       = 16;
    localparam int QUEUE_DEPTH = 2;

    // divide by ten: (v * 0xCCCD) >> 19 is exact for every 16-bit v
    localparam logic [2*MAG_W-1:0] DIV10_RECIP = 32'd52429;
    localparam int                 DIV10_SHIFT = 19;

    localparam logic [1:0] MODE_UDEC = 2'd0;
    localparam logic [1:0] MODE_SDEC = 2'd1;
    localparam logic [1:0] MODE_HEX  = 2'd2;
    localparam logic [1:0] MODE_BIN  = 2'd3;

    localparam logic [1:0] LINE_ONE = 2'd1;
    localparam logic [1:0] LINE_TWO = 2'd2;

    localparam logic [7:0] CMD_SET_CURSOR  = 8'h80;
    localparam logic [7:0] LINE_TWO_OFFSET = 8'h40;
    localparam logic [7:0] CHAR_ZERO       = 8'h30;
    localparam logic [7:0] CHAR_A          = 8'h41;
    localparam logic [7:0] CHAR_PLUS       = 8'h2B;
    localparam logic [7:0] CHAR_MINUS      = 8'h2D;

    typedef struct packed {
        logic                             has_cmd;
        logic [7:0]                       cmd_byte;
        logic                             has_sign;
        logic                             neg;
        logic [CNT_W-1:0]                 count;
        logic [MAX_DIGITS-1:0][3:0]       digits;
    } job_t;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_CONV = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_CMD   = 4'b0010,
        B_SIGN  = 4'b0100,
        B_DIGIT = 4'b1000
    } back_state_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] ch;
        if (d < 4'd10) begin
            ch = CHAR_ZERO + 8'(d);
        end else begin
            ch = CHAR_A + 8'(d) - 8'd10;
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

[hdl/lnfw_front.sv]
// front end: takes a request, builds the cursor command and sign, converts digits
`default_nettype none

module lnfw_front
    import lnfw_pkg::*;
#(
    parameter int NUMBER_WIDTH = 16
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [1:0]       mode,
    input  wire logic [1:0]       line,
    input  wire logic [4:0]       column,
    input  wire logic [MAG_W-1:0] number,
    input  wire logic [4:0]       digit_count,
    output logic                  q_valid,
    input  wire logic             q_ready,
    output job_t                  q_data
);

    localparam int VW = (NUMBER_WIDTH < MAG_W) ? NUMBER_WIDTH : MAG_W;

    front_state_t           state_reg, state_next;
    job_t                   job_reg;
    logic [MAG_W-1:0]       val_reg;
    logic [1:0]             mode_reg;
    logic [DIG_IDX_W-1:0]   idx_reg, idx_next;

    logic [VW-1:0]          val_in;
    logic [VW-1:0]          neg_val;
    logic                   neg;
    logic [MAG_W-1:0]       mag;
    logic                   has_cmd;
    logic [7:0]             cmd_byte;
    logic [CNT_W-1:0]       cnt_sat;
    logic                   has_writes;
    logic                   accept;

    logic [2*MAG_W-1:0]     prod;
    logic [MAG_W-1:0]       quot10;
    logic [MAG_W-1:0]       rem10;
    logic [3:0]             dig;
    logic [MAG_W-1:0]       quot;
    logic                   conv_done;

    // classify the incoming request
    always_comb begin
        val_in  = number[VW-1:0];
        neg_val = ~val_in + {{(VW-1){1'b0}}, 1'b1};
        // the sign bit lies outside the 16-bit field when the number is wider
        neg     = (mode == MODE_SDEC) && (NUMBER_WIDTH <= MAG_W) && val_in[VW-1];
        mag     = neg ? MAG_W'(neg_val) : MAG_W'(val_in);

        unique case (line)
            LINE_ONE: begin
                has_cmd  = 1'b1;
                cmd_byte = CMD_SET_CURSOR | (8'(column) - 8'd1);
            end
            LINE_TWO: begin
                has_cmd  = 1'b1;
                cmd_byte = CMD_SET_CURSOR | (8'(column) - 8'd1 + LINE_TWO_OFFSET);
            end
            default: begin
                has_cmd  = 1'b0;
                cmd_byte = CMD_SET_CURSOR;
            end
        endcase

        cnt_sat    = (digit_count > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS) : digit_count;
        has_writes = has_cmd || (mode == MODE_SDEC) || (cnt_sat != '0);
        accept     = s_valid && (state_reg == F_IDLE);
    end

    // one digit per cycle, least significant first
    always_comb begin
        prod   = {{MAG_W{1'b0}}, val_reg} * DIV10_RECIP;
        quot10 = MAG_W'(prod >> DIV10_SHIFT);
        rem10  = val_reg - ((quot10 << 3) + (quot10 << 1));
        case (mode_reg)
            MODE_HEX: begin
                dig  = val_reg[3:0];
                quot = val_reg >> 4;
            end
            MODE_BIN: begin
                dig  = {3'b000, val_reg[0]};
                quot = val_reg >> 1;
            end
            default: begin
                dig  = rem10[3:0];
                quot = quot10;
            end
        endcase
        conv_done = ((CNT_W'(idx_reg) + CNT_W'(1)) == job_reg.count);
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            F_IDLE: begin
                idx_next = '0;
                if (accept && has_writes) begin
                    state_next = (cnt_sat != '0) ? F_CONV : F_PUSH;
                end
            end
            F_CONV: begin
                idx_next = idx_reg + DIG_IDX_W'(1);
                if (conv_done) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (q_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            job_reg.has_cmd  <= has_cmd;
            job_reg.cmd_byte <= cmd_byte;
            job_reg.has_sign <= (mode == MODE_SDEC);
            job_reg.neg      <= neg;
            job_reg.count    <= cnt_sat;
            val_reg          <= mag;
            mode_reg         <= mode;
        end else if (state_reg == F_CONV) begin
            job_reg.digits[idx_reg] <= dig;
            val_reg                 <= quot;
        end
    end

    assign s_ready = (state_reg == F_IDLE);
    assign q_valid = (state_reg == F_PUSH);
    assign q_data  = job_reg;

endmodule

`default_nettype wire

[hdl/lnfw_queue.sv]
// two-entry queue of converted jobs between front and back
`default_nettype none

module lnfw_queue
    import lnfw_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire job_t in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output job_t      out_data
);

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t               entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               push;
    logic               pop;

    always_comb begin
        in_ready    = (count_reg != COUNT_W'(QUEUE_DEPTH));
        out_valid   = (count_reg != '0);
        push        = in_valid && in_ready;
        pop         = out_valid && out_ready;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + COUNT_W'(push) - COUNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

    assign out_data = entry_reg[rd_ptr_reg];

endmodule

`default_nettype wire

[hdl/lnfw_back.sv]
// back end: sends the command, sign and digit writes of one job through an output register
`default_nettype none

module lnfw_back
    import lnfw_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic q_valid,
    output logic      q_ready,
    input  wire job_t q_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output logic      m_is_data,
    output logic [7:0] m_byte,
    output logic      m_last
);

    back_state_t      state_reg, state_next;
    job_t             job_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_is_data_reg, m_is_data_next;
    logic [7:0]       m_byte_reg, m_byte_next;
    logic             m_last_reg, m_last_next;

    logic             out_free;
    logic             load;
    logic [CNT_W-1:0] cnt_m1;

    always_comb begin
        out_free       = !m_valid_reg || m_ready;
        load           = (state_reg == B_IDLE) && q_valid;
        cnt_m1         = cnt_reg - CNT_W'(1);
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_is_data_next = m_is_data_reg;
        m_byte_next    = m_byte_reg;
        m_last_next    = m_last_reg;

        unique case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    cnt_next = q_data.count;
                    if (q_data.has_cmd) begin
                        state_next = B_CMD;
                    end else if (q_data.has_sign) begin
                        state_next = B_SIGN;
                    end else begin
                        state_next = B_DIGIT;
                    end
                end
            end
            B_CMD: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_is_data_next = 1'b0;
                    m_byte_next    = job_reg.cmd_byte;
                    m_last_next    = !job_reg.has_sign && (cnt_reg == '0);
                    if (job_reg.has_sign) begin
                        state_next = B_SIGN;
                    end else if (cnt_reg != '0) begin
                        state_next = B_DIGIT;
                    end else begin
                        state_next = B_IDLE;
                    end
                end
            end
            B_SIGN: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_is_data_next = 1'b1;
                    m_byte_next    = job_reg.neg ? CHAR_MINUS : CHAR_PLUS;
                    m_last_next    = (cnt_reg == '0);
                    state_next     = (cnt_reg != '0) ? B_DIGIT : B_IDLE;
                end
            end
            B_DIGIT: begin
                if (out_free) begin
                    // digits were stored least significant first, read them back down
                    m_valid_next   = 1'b1;
                    m_is_data_next = 1'b1;
                    m_byte_next    = digit_char(job_reg.digits[cnt_m1[DIG_IDX_W-1:0]]);
                    m_last_next    = (cnt_m1 == '0);
                    cnt_next       = cnt_m1;
                    if (cnt_m1 == '0) begin
                        state_next = B_IDLE;
                    end
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_is_data_reg <= m_is_data_next;
        m_byte_reg    <= m_byte_next;
        m_last_reg    <= m_last_next;
        if (load) begin
            job_reg <= q_data;
        end
    end

    assign q_ready   = (state_reg == B_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_is_data = m_is_data_reg;
    assign m_byte    = m_byte_reg;
    assign m_last    = m_last_reg;

endmodule

`default_nettype wire

[hdl/lcd_number_field_writer.sv]
// the front converts one digit per cycle (reciprocal multiply for decimal) and takes
// a new request only after pushing the last job into the queue; the back sends one
// bus write per cycle while m_tready is high, and a two-entry queue lets them overlap;
// a request makes up to 18 writes (cursor command, sign and up to sixteen digits)
// reset: synchronous active-low aresetn empties the queue and drops any pending write
`default_nettype none

module lcd_number_field_writer
    import lnfw_pkg::*;
#(
    parameter int NUMBER_WIDTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // mode[1:0], line[3:2], column[8:4], number[24:9], digit_count[29:25], zero[31:30]
    input  wire logic [31:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // bus_byte[7:0]
    output logic [7:0]       m_tdata,
    // is_data[0]
    output logic             m_tuser,
    output logic             m_tlast
);

    logic fq_valid, fq_ready;
    job_t fq_data;
    logic qb_valid, qb_ready;
    job_t qb_data;

    lnfw_front #(
        .NUMBER_WIDTH(NUMBER_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .mode       (s_tdata[1:0]),
        .line       (s_tdata[3:2]),
        .column     (s_tdata[8:4]),
        .number     (s_tdata[24:9]),
        .digit_count(s_tdata[29:25]),
        .q_valid    (fq_valid),
        .q_ready    (fq_ready),
        .q_data     (fq_data)
    );

    lnfw_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (fq_valid),
        .in_ready (fq_ready),
        .in_data  (fq_data),
        .out_valid(qb_valid),
        .out_ready(qb_ready),
        .out_data (qb_data)
    );

    lnfw_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (qb_valid),
        .q_ready  (qb_ready),
        .q_data   (qb_data),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_is_data(m_tuser),
        .m_byte   (m_tdata),
        .m_last   (m_tlast)
    );

endmodule

`default_nettype wire

[hdl/lnfw_checker.sv]
// port-level checks for the lcd number field writer, bound to the top level
`default_nettype none

module lnfw_checker
    import lnfw_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tuser,
    input wire logic       m_tlast
);

    logic in_run_reg;

    // set between the first and the last write of one request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_run_reg <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            in_run_reg <= !m_tlast;
        end
    end

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled item changed");

    a_cmd_starts_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> !in_run_reg && m_tdata[7])
        else $error("command write inside a run or without set-cursor bit");

    a_char_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            (m_tdata >= CHAR_ZERO && m_tdata <= 8'h39) ||
            (m_tdata >= CHAR_A && m_tdata <= 8'h46) ||
            m_tdata == CHAR_PLUS || m_tdata == CHAR_MINUS)
        else $error("character write outside digit and sign set");

endmodule

bind lcd_number_field_writer lnfw_checker u_lnfw_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
);

`default_nettype wire

[sim/tb_lcd_number_field_writer.sv]
// testbench for the lcd number field writer: directed table plus random requests, checked per write
`default_nettype none

module tb_lcd_number_field_writer;
    import lnfw_pkg::*;

    typedef struct packed {
        logic       is_data;
        logic [7:0] bus_byte;
        logic       last;
    } lcd_write_t;

    // one row of the directed table; text holds the characters, right-justified
    typedef struct packed {
        logic [1:0]   mode;
        logic [1:0]   line;
        logic [4:0]   column;
        logic [15:0]  number;
        logic [4:0]   count;
        logic         typed;
        logic [7:0]   cmd;
        logic [143:0] text;
    } field_case_t;

    typedef enum int {
        READY_ALWAYS,
        READY_RANDOM,
        READY_THREE_OF_FOUR,
        READY_SPARSE
    } stall_style_t;

    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 125;
    localparam int SETTLE_CYCLES = 60;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    lcd_write_t  pending_writes[$];
    lcd_write_t  request_writes[$];
    field_case_t directed_cases[$];

    int error_count   = 0;
    int hold_requests = 0;
    int burst_left    = 0;
    int no_gap_items  = 0;

    lcd_number_field_writer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever begin
            #5 aclk = ~aclk;
        end
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < 100) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
        error_count++;
    endtask

    function automatic logic [31:0] pack_request(input logic [1:0] mode, input logic [1:0] line,
                                                 input logic [4:0] column,
                                                 input logic [15:0] number,
                                                 input logic [4:0] count);
        return {2'b00, count, number, column, line, mode};
    endfunction

    task automatic add_case(input logic [1:0] mode, input logic [1:0] line,
                            input logic [4:0] column, input logic [15:0] number,
                            input logic [4:0] count, input logic typed,
                            input logic [7:0] cmd, input logic [143:0] text);
        field_case_t row;
        row = '{mode, line, column, number, count, typed, cmd, text};
        directed_cases.push_back(row);
    endtask

    // predicted bus writes for one request, appended to request_writes
    task automatic predict_field_writes(input logic [1:0] mode, input logic [1:0] line,
                                        input logic [4:0] column, input logic [15:0] number,
                                        input logic [4:0] count);
        logic [7:0]  col_off;
        logic [15:0] magnitude;
        int unsigned value;
        int unsigned radix;
        int unsigned width;
        int unsigned digit[MAX_DIGITS];
        col_off = 8'({3'b000, column}) - 8'd1;
        width = (count > 5'(MAX_DIGITS)) ? MAX_DIGITS : int'(count);
        if (line == LINE_ONE) begin
            request_writes.push_back('{1'b0, CMD_SET_CURSOR | col_off, 1'b0});
        end else if (line == LINE_TWO) begin
            request_writes.push_back('{1'b0, CMD_SET_CURSOR | (col_off + LINE_TWO_OFFSET),
                                       1'b0});
        end
        magnitude = number;
        if (mode == MODE_SDEC) begin
            if (number[15]) begin
                // negating the most negative value leaves it as its own magnitude
                magnitude = -number;
                request_writes.push_back('{1'b1, CHAR_MINUS, 1'b0});
            end else begin
                request_writes.push_back('{1'b1, CHAR_PLUS, 1'b0});
            end
        end
        radix = (mode == MODE_HEX) ? 16 : (mode == MODE_BIN) ? 2 : 10;
        value = magnitude;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            digit[i] = value % radix;
            value = value / radix;
        end
        for (int i = int'(width) - 1; i >= 0; i--) begin
            if (digit[i] < 10) begin
                request_writes.push_back('{1'b1, CHAR_ZERO + 8'(digit[i]), 1'b0});
            end else begin
                request_writes.push_back('{1'b1, CHAR_A + 8'(digit[i] - 10), 1'b0});
            end
        end
    endtask

    task automatic queue_typed_writes(input field_case_t row);
        if (row.line == LINE_ONE || row.line == LINE_TWO) begin
            request_writes.push_back('{1'b0, row.cmd, 1'b0});
        end
        for (int i = 17; i >= 0; i--) begin
            if (row.text[8*i +: 8] != 8'd0) begin
                request_writes.push_back('{1'b1, row.text[8*i +: 8], 1'b0});
            end
        end
    endtask

    task automatic post_request();
        if (request_writes.size() > 0) begin
            request_writes[request_writes.size() - 1].last = 1'b1;
        end
        foreach (request_writes[i]) begin
            pending_writes.push_back(request_writes[i]);
        end
        request_writes.delete();
    endtask

    task automatic offer_item(input logic [31:0] data);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        do begin
            @(posedge aclk);
        end while (!s_tready);
    endtask

    task automatic sender_gap();
        int gap;
        if (no_gap_items > 0) begin
            no_gap_items--;
        end else if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 8);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            repeat (gap - 1) @(negedge aclk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_writes.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // receiver: changing stall styles, plus long holds on request
    initial begin
        stall_style_t style;
        int style_left;
        int phase;
        int hold_left;
        int holds_served;
        style        = READY_ALWAYS;
        style_left   = 0;
        phase        = 0;
        hold_left    = 0;
        holds_served = 0;
        forever begin
            @(negedge aclk);
            if (hold_left == 0 && holds_served != hold_requests) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (style_left == 0) begin
                    style      = stall_style_t'($urandom_range(0, 3));
                    style_left = $urandom_range(40, 200);
                end
                style_left--;
                phase++;
                case (style)
                    READY_ALWAYS:        m_tready <= 1'b1;
                    READY_RANDOM:        m_tready <= 1'($urandom_range(0, 1));
                    READY_THREE_OF_FOUR: m_tready <= (phase % 4) != 3;
                    default:             m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        lcd_write_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_writes.size() == 0) begin
                report_mismatch($sformatf("unexpected write: is_data %0b byte %02h last %0b",
                                          m_tuser, m_tdata, m_tlast));
            end else begin
                want = pending_writes.pop_front();
                if (m_tuser !== want.is_data) begin
                    report_mismatch($sformatf("is_data %0b, expected %0b (byte %02h)",
                                              m_tuser, want.is_data, want.bus_byte));
                end
                if (m_tdata !== want.bus_byte) begin
                    report_mismatch($sformatf("bus_byte %02h, expected %02h",
                                              m_tdata, want.bus_byte));
                end
                if (m_tlast !== want.last) begin
                    report_mismatch($sformatf("last %0b, expected %0b (byte %02h)",
                                              m_tlast, want.last, want.bus_byte));
                end
            end
        end
    end

    initial begin
        field_case_t row;
        logic [1:0]  mode;
        logic [1:0]  line;
        logic [4:0]  column;
        logic [15:0] number;
        logic [4:0]  count;

        add_case(MODE_UDEC, LINE_ONE, 5'd1,  16'h0000, 5'd1,  1'b1, 8'h80, "0");
        add_case(MODE_UDEC, LINE_TWO, 5'd16, 16'hFFFF, 5'd5,  1'b1, 8'hCF, "65535");
        add_case(MODE_SDEC, LINE_ONE, 5'd1,  16'h0000, 5'd3,  1'b1, 8'h80, "+000");
        add_case(MODE_SDEC, LINE_ONE, 5'd2,  16'h8000, 5'd5,  1'b1, 8'h81, "-32768");
        add_case(MODE_SDEC, LINE_TWO, 5'd1,  16'h7FFF, 5'd5,  1'b1, 8'hC0, "+32767");
        add_case(MODE_SDEC, 2'd3,     5'd4,  16'hFFFF, 5'd1,  1'b1, 8'h00, "-1");
        add_case(MODE_HEX,  LINE_ONE, 5'd5,  16'hABCD, 5'd4,  1'b1, 8'h84, "ABCD");
        add_case(MODE_HEX,  2'd0,     5'd1,  16'h001F, 5'd16, 1'b1, 8'h00, "000000000000001F");
        add_case(MODE_BIN,  LINE_ONE, 5'd1,  16'hFFFF, 5'd16, 1'b1, 8'h80, "1111111111111111");
        add_case(MODE_BIN,  2'd3,     5'd7,  16'h0005, 5'd3,  1'b1, 8'h00, "101");
        // column zero wraps
        add_case(MODE_UDEC, LINE_ONE, 5'd0,  16'h0007, 5'd1,  1'b1, 8'hFF, "7");
        add_case(MODE_UDEC, LINE_TWO, 5'd0,  16'h0009, 5'd1,  1'b1, 8'hBF, "9");
        add_case(MODE_HEX,  LINE_ONE, 5'd31, 16'h00F0, 5'd2,  1'b1, 8'h9E, "F0");
        add_case(MODE_HEX,  LINE_TWO, 5'd31, 16'h0F00, 5'd3,  1'b1, 8'hDE, "F00");
        // count above sixteen saturates
        add_case(MODE_UDEC, 2'd0,     5'd1,  16'd12345, 5'd31, 1'b1, 8'h00, "0000000000012345");
        // zero count: nothing at all, sign only, command only
        add_case(MODE_UDEC, 2'd0,     5'd1,  16'd1234, 5'd0,  1'b1, 8'h00, "");
        add_case(MODE_SDEC, 2'd0,     5'd1,  16'h8000, 5'd0,  1'b1, 8'h00, "-");
        add_case(MODE_UDEC, LINE_ONE, 5'd3,  16'd4321, 5'd0,  1'b1, 8'h82, "");
        // narrow fields keep the low digits
        add_case(MODE_UDEC, 2'd3,     5'd1,  16'hFFFF, 5'd2,  1'b1, 8'h00, "35");
        add_case(MODE_HEX,  2'd0,     5'd1,  16'hABCD, 5'd2,  1'b1, 8'h00, "CD");
        add_case(MODE_UDEC, LINE_TWO, 5'd1,  16'h0000, 5'd16, 1'b1, 8'hC0, "0000000000000000");
        add_case(MODE_SDEC, LINE_TWO, 5'd16, 16'hFFFF, 5'd17, 1'b1, 8'hCF, "-0000000000000001");
        add_case(MODE_SDEC, LINE_TWO, 5'd9,  16'h1234, 5'd7,  1'b0, 8'h00, "");
        add_case(MODE_BIN,  LINE_ONE, 5'd12, 16'hA5A5, 5'd10, 1'b0, 8'h00, "");
        add_case(MODE_HEX,  2'd3,     5'd16, 16'hFFFF, 5'd30, 1'b0, 8'h00, "");

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_cases[i]) begin
            row = directed_cases[i];
            offer_item(pack_request(row.mode, row.line, row.column, row.number, row.count));
            if (row.typed) begin
                queue_typed_writes(row);
            end else begin
                predict_field_writes(row.mode, row.line, row.column, row.number, row.count);
            end
            post_request();
            sender_gap();
        end
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 40) begin
                // long receiver hold while the sender keeps pushing
                hold_requests++;
                no_gap_items = 12;
            end
            if (n == 100) begin
                wait_drained();
            end
            mode   = 2'($urandom_range(0, 3));
            line   = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3))
                                                 : 2'($urandom_range(1, 2));
            column = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                                 : 5'($urandom_range(1, 16));
            if ($urandom_range(0, 9) == 0) begin
                count = 5'($urandom_range(0, 31));
            end else if ($urandom_range(0, 3) == 0) begin
                count = 5'($urandom_range(1, 4));
            end else begin
                count = 5'($urandom_range(1, 16));
            end
            case ($urandom_range(0, 5))
                0: begin
                    case ($urandom_range(0, 4))
                        0:       number = 16'h0000;
                        1:       number = 16'hFFFF;
                        2:       number = 16'h8000;
                        3:       number = 16'h7FFF;
                        default: number = 16'h0001;
                    endcase
                end
                1:       number = 16'($urandom_range(0, 255));
                2:       number = 16'hFFFF - 16'($urandom_range(0, 255));
                default: number = 16'($urandom);
            endcase
            offer_item(pack_request(mode, line, column, number, count));
            predict_field_writes(mode, line, column, number, count);
            post_request();
            sender_gap();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_writes.size() != 0) begin
            report_mismatch($sformatf("%0d writes never arrived", pending_writes.size()));
        end
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
hdl/lnfw_pkg.sv
hdl/lnfw_front.sv
hdl/lnfw_queue.sv
hdl/lnfw_back.sv
hdl/lcd_number_field_writer.sv
hdl/lnfw_checker.sv
sim/tb_lcd_number_field_writer.sv
